@@ rtl/core/nmc_pkg.sv @@
// Shared types and constants for the normal map classifier.
// Used by nmc_accum, nmc_verdict and normal_map_classifier_unit; no dependencies.
package nmc_pkg;

    // Per-pixel sample test.
    localparam logic [7:0]  ALPHA_MAX = 8'd25;
    localparam logic [7:0]  BLUE_MIN  = 8'd102;
    localparam logic [17:0] S_MIN     = 18'd32513;
    localparam logic [17:0] S_MAX     = 18'd104040;

    // Final decision: channel means, blue floor and valid-normal fraction,
    // all rescaled to exact integer products.
    localparam int MEAN_LO   = 357;
    localparam int MEAN_HI   = 663;
    localparam int VALID_NUM = 10;
    localparam int VALID_DEN = 7;

    // Output verdict queue.
    localparam int Q_DEPTH = 8;
    localparam int Q_PTR_W = 3;
    localparam int Q_CNT_W = 4;

    // One verdict, packed so that is_normal_map is bit 0.
    typedef struct packed {
        logic no_samples;
        logic is_normal_map;
    } nmc_result_t;

endpackage

@@ rtl/core/nmc_accum.sv @@
// Per-pixel sample test and running accumulators of the normal map classifier.
// Depends on nmc_pkg.
module nmc_accum
    import nmc_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096,
    parameter int CNT_W       = 13,
    parameter int SUM_W       = 21
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             pix_valid,
    input  logic [7:0]       red,
    input  logic [7:0]       green,
    input  logic [7:0]       blue,
    input  logic [7:0]       alpha,
    input  logic             last,
    output logic             snap_valid,
    output logic [SUM_W-1:0] snap_sum_red,
    output logic [SUM_W-1:0] snap_sum_green,
    output logic [SUM_W-1:0] snap_sum_blue,
    output logic [CNT_W-1:0] snap_samples,
    output logic [CNT_W-1:0] snap_valids
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    // |2c - 255| is always odd; its upper bits are c[6:0] or its complement.
    function automatic logic [15:0] sq_centered(input logic [7:0] c);
        logic [7:0] d;
        d = {(c[7] ? c[6:0] : ~c[6:0]), 1'b1};
        return d * d;
    endfunction

    logic [SUM_W-1:0] sum_red_reg, sum_green_reg, sum_blue_reg;
    logic [SUM_W-1:0] sum_red_next, sum_green_next, sum_blue_next;
    logic [CNT_W-1:0] samples_reg, samples_next;
    logic [CNT_W-1:0] valids_reg, valids_next;
    logic             snap_valid_reg;
    logic [SUM_W-1:0] snap_red_reg, snap_green_reg, snap_blue_reg;
    logic [CNT_W-1:0] snap_samples_reg, snap_valids_reg;
    logic             take;
    logic             good_normal;
    logic [17:0]      s_val;

    assign take  = pix_valid && (alpha > ALPHA_MAX) && (samples_reg < MAX_CNT);
    assign s_val = 18'(sq_centered(red)) + 18'(sq_centered(green))
                 + 18'(sq_centered(blue));
    assign good_normal = (s_val >= S_MIN) && (s_val <= S_MAX) && (blue > BLUE_MIN);

    always_comb begin
        sum_red_next   = sum_red_reg;
        sum_green_next = sum_green_reg;
        sum_blue_next  = sum_blue_reg;
        samples_next   = samples_reg;
        valids_next    = valids_reg;
        if (take) begin
            sum_red_next   = sum_red_reg   + SUM_W'(red);
            sum_green_next = sum_green_reg + SUM_W'(green);
            sum_blue_next  = sum_blue_reg  + SUM_W'(blue);
            samples_next   = samples_reg + 1'b1;
            if (good_normal) begin
                valids_next = valids_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_red_reg    <= '0;
            sum_green_reg  <= '0;
            sum_blue_reg   <= '0;
            samples_reg    <= '0;
            valids_reg     <= '0;
            snap_valid_reg <= 1'b0;
        end else begin
            snap_valid_reg <= pix_valid && last;
            if (pix_valid && last) begin
                sum_red_reg   <= '0;
                sum_green_reg <= '0;
                sum_blue_reg  <= '0;
                samples_reg   <= '0;
                valids_reg    <= '0;
            end else begin
                sum_red_reg   <= sum_red_next;
                sum_green_reg <= sum_green_next;
                sum_blue_reg  <= sum_blue_next;
                samples_reg   <= samples_next;
                valids_reg    <= valids_next;
            end
        end
    end

    // Totals of a finished image, including its last pixel.
    always_ff @(posedge aclk) begin
        if (pix_valid && last) begin
            snap_red_reg     <= sum_red_next;
            snap_green_reg   <= sum_green_next;
            snap_blue_reg    <= sum_blue_next;
            snap_samples_reg <= samples_next;
            snap_valids_reg  <= valids_next;
        end
    end

    assign snap_valid     = snap_valid_reg;
    assign snap_sum_red   = snap_red_reg;
    assign snap_sum_green = snap_green_reg;
    assign snap_sum_blue  = snap_blue_reg;
    assign snap_samples   = snap_samples_reg;
    assign snap_valids    = snap_valids_reg;

endmodule

@@ rtl/core/nmc_verdict.sv @@
// Two-stage verdict logic: scaled products, then comparisons.
// Depends on nmc_pkg.
module nmc_verdict
    import nmc_pkg::*;
#(
    parameter int CNT_W = 13,
    parameter int SUM_W = 21
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             grayscale,
    input  logic             snap_valid,
    input  logic [SUM_W-1:0] snap_sum_red,
    input  logic [SUM_W-1:0] snap_sum_green,
    input  logic [SUM_W-1:0] snap_sum_blue,
    input  logic [CNT_W-1:0] snap_samples,
    input  logic [CNT_W-1:0] snap_valids,
    output logic             res_valid,
    output nmc_result_t      res
);

    localparam int PROD_W = SUM_W + 2;
    localparam logic [PROD_W-1:0] K_LO  = PROD_W'(MEAN_LO);
    localparam logic [PROD_W-1:0] K_HI  = PROD_W'(MEAN_HI);
    localparam logic [PROD_W-1:0] K_NUM = PROD_W'(VALID_NUM);
    localparam logic [PROD_W-1:0] K_DEN = PROD_W'(VALID_DEN);

    logic              prod_valid_reg;
    logic [PROD_W-1:0] lo_reg, hi_reg, num_reg, den_reg;
    logic [PROD_W-1:0] q_red_reg, q_green_reg, q_blue_reg;
    logic              empty_reg;
    logic              res_valid_reg;
    nmc_result_t       res_reg;
    logic              verdict;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            prod_valid_reg <= snap_valid;
            res_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid) begin
            lo_reg      <= PROD_W'(snap_samples) * K_LO;
            hi_reg      <= PROD_W'(snap_samples) * K_HI;
            den_reg     <= PROD_W'(snap_samples) * K_DEN;
            num_reg     <= PROD_W'(snap_valids) * K_NUM;
            q_red_reg   <= {snap_sum_red, 2'b00};
            q_green_reg <= {snap_sum_green, 2'b00};
            q_blue_reg  <= {snap_sum_blue, 2'b00};
            empty_reg   <= (snap_samples == '0);
        end
    end

    assign verdict = !grayscale && !empty_reg
                   && (num_reg > den_reg)
                   && (q_red_reg > lo_reg) && (q_red_reg < hi_reg)
                   && (q_green_reg > lo_reg) && (q_green_reg < hi_reg)
                   && (q_blue_reg > hi_reg);

    always_ff @(posedge aclk) begin
        if (prod_valid_reg) begin
            res_reg.is_normal_map <= verdict;
            res_reg.no_samples    <= empty_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ rtl/core/normal_map_classifier_unit.sv @@
// Top level of the normal map classifier: input register, accumulators,
// verdict stages and output queue. Depends on nmc_pkg, nmc_accum and nmc_verdict.
//
// The unit takes one RGBA pixel request per clock cycle while s_tready is
// high and, for each image (a run of pixels closed by tlast), returns one
// verdict request saying whether the image looks like a tangent-space normal
// map. Pixels with alpha of 25 or below are skipped; once MAX_SAMPLES pixels
// of an image have been counted, the rest of that image is ignored. A verdict
// passes through the input register, the accumulators, the scaled products,
// the comparison register and the output queue before it appears on the
// output. Up to eight verdicts wait in a small output queue, so the input
// keeps running while results are not taken. Eight covers the round trip
// from a last pixel to the delivery of its verdict, so even one-pixel images
// stream at one request per cycle while the receiver is ready; s_tready falls
// only when eight images have been closed and their verdicts not yet
// delivered. The grayscale_source register (cfg_wr_data, written when
// cfg_wr_en is high) forces the verdict to zero and should only change while
// no image is in flight.
module normal_map_classifier_unit
    import nmc_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: grayscale_source.
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // Pixel input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    input  logic        s_tlast,    // last_sample
    // Verdict output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata     // is_normal_map[0], no_samples[1], zero[7:2]
);

    // Counters must hold MAX_SAMPLES itself; sums hold that many 8-bit values.
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = CNT_W + 8;

    // Configuration register.
    logic grayscale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grayscale_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            grayscale_reg <= cfg_wr_data;
        end
    end

    // Input register. Every accepted pixel moves on the next cycle, so the
    // only back pressure comes from the verdict credit count below.
    logic        s_hs;
    logic        pix_valid_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg;
    logic        last_reg;

    assign s_hs = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_valid_reg <= 1'b0;
        end else begin
            pix_valid_reg <= s_hs;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_hs) begin
            red_reg   <= s_tdata[7:0];
            green_reg <= s_tdata[15:8];
            blue_reg  <= s_tdata[23:16];
            alpha_reg <= s_tdata[31:24];
            last_reg  <= s_tlast;
        end
    end

    // Accumulators and the per-image snapshot.
    logic             snap_valid;
    logic [SUM_W-1:0] snap_sum_red, snap_sum_green, snap_sum_blue;
    logic [CNT_W-1:0] snap_samples, snap_valids;

    nmc_accum #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_accum (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pix_valid      (pix_valid_reg),
        .red            (red_reg),
        .green          (green_reg),
        .blue           (blue_reg),
        .alpha          (alpha_reg),
        .last           (last_reg),
        .snap_valid     (snap_valid),
        .snap_sum_red   (snap_sum_red),
        .snap_sum_green (snap_sum_green),
        .snap_sum_blue  (snap_sum_blue),
        .snap_samples   (snap_samples),
        .snap_valids    (snap_valids)
    );

    // Verdict stages.
    logic        res_valid;
    nmc_result_t res;

    nmc_verdict #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_verdict (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .grayscale      (grayscale_reg),
        .snap_valid     (snap_valid),
        .snap_sum_red   (snap_sum_red),
        .snap_sum_green (snap_sum_green),
        .snap_sum_blue  (snap_sum_blue),
        .snap_samples   (snap_samples),
        .snap_valids    (snap_valids),
        .res_valid      (res_valid),
        .res            (res)
    );

    // Output queue. The credit count tracks verdicts from the acceptance of
    // the last pixel until delivery, so the queue can never overflow and the
    // pipeline never has to stall.
    logic               m_hs;
    logic               last_hs;
    logic [Q_CNT_W-1:0] credit_reg, credit_next;
    logic [Q_CNT_W-1:0] q_cnt_reg, q_cnt_next;
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    nmc_result_t        q_mem_reg [Q_DEPTH];

    assign m_hs    = m_tvalid && m_tready;
    assign last_hs = s_hs && s_tlast;

    always_comb begin
        credit_next = credit_reg;
        if (last_hs && !m_hs) begin
            credit_next = credit_reg + 1'b1;
        end else if (!last_hs && m_hs) begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_comb begin
        q_cnt_next = q_cnt_reg;
        if (res_valid && !m_hs) begin
            q_cnt_next = q_cnt_reg + 1'b1;
        end else if (!res_valid && m_hs) begin
            q_cnt_next = q_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
            q_cnt_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            credit_reg <= credit_next;
            q_cnt_reg  <= q_cnt_next;
            if (res_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (m_hs) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            q_mem_reg[wr_ptr_reg] <= res;
        end
    end

    assign s_tready = (credit_reg < Q_CNT_W'(Q_DEPTH));
    assign m_tvalid = (q_cnt_reg != '0);
    assign m_tdata  = {6'b0, q_mem_reg[rd_ptr_reg]};

endmodule

@@ rtl/core/nmc_checker.sv @@
// Port-level assertions for normal_map_classifier_unit, with its bind.
// Depends on normal_map_classifier_unit's port list only.
module nmc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // No verdict is pending right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("verdict visible right after reset");

    // A waiting verdict holds until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("verdict changed or dropped while stalled");

    // An image with no samples can never be classified as a normal map.
    a_empty_not_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("normal map verdict on an empty image");

    // Padding bits stay zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:2] == 6'b0))
        else $error("nonzero padding in verdict");

endmodule

bind normal_map_classifier_unit nmc_checker u_nmc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/tb_top.sv @@
// Self-checking testbench for normal_map_classifier_unit: drives pixel requests,
// predicts each image verdict in step and checks every verdict request.
// Depends on nmc_pkg and the unit itself.
`timescale 1ns / 100ps

module tb_top;
    import nmc_pkg::*;

    // Sample ceiling per image; handed to the unit so both sides agree.
    localparam int MAX_SAMP = 4096;
    // Cycles allowed for the pipeline to settle once nothing is expected.
    localparam int SETTLE = 8;
    // Upper bound on the final drain, in cycles.
    localparam int DRAIN_LIMIT = 4000;
    // Length of the long receiver stall, in cycles.
    localparam int HOLD_CYCLES = 400;

    // One pixel request as it sits in tdata, plus the end-of-image flag.
    typedef struct packed {
        logic       last;
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // Flavors of generated images.
    typedef enum int {
        IMG_NORMAL,     // mostly plausible tangent-space normals
        IMG_BORDER,     // channel values sitting on the decision thresholds
        IMG_NOISE,      // fully random pixels
        IMG_SPARSE      // mostly pixels that fail the alpha test
    } img_kind_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    // Pixels waiting to be offered, and the request currently on the bus.
    pixel_t      pixel_q[$];
    pixel_t      cur_px = '0;

    // Verdicts the unit still owes us, oldest first.
    nmc_result_t verdict_q[$];

    // Shadow of the unit's image state and its one configuration bit.
    logic [19:0] sum_r = '0;
    logic [19:0] sum_g = '0;
    logic [19:0] sum_b = '0;
    logic [12:0] n_samples = '0;
    logic [12:0] n_valid = '0;
    logic        gray_cfg = 1'b0;

    // Idle percentages for each side, and the receiver hold-off control.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left = 0;
    logic hold_go = 1'b0;
    logic hold_armed = 1'b0;

    int fail_cnt = 0;
    int pixels_sent = 0;
    int verdicts_seen = 0;
    int verdicts_true = 0;
    int verdicts_empty = 0;

    normal_map_classifier_unit #(
        .MAX_SAMPLES (MAX_SAMP)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Generous ceiling; the slowest legal run needs well under a tenth of it.
    initial begin
        #400_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Verdict prediction
    // ------------------------------------------------------------------

    // (2c - 255)^2, the squared distance of a channel from the mid code.
    function automatic int unsigned centered_sq(input logic [7:0] c);
        int unsigned d;
        d = (c >= 8'd128) ? 2 * c - 255 : 255 - 2 * c;
        return d * d;
    endfunction

    // Accounts one accepted pixel. A pixel that closes an image appends the
    // verdict the unit must produce and clears the image state.
    function automatic void tally_pixel(input pixel_t px);
        int unsigned s;
        int unsigned n;
        int unsigned qr;
        int unsigned qg;
        int unsigned qb;
        nmc_result_t res;
        // Pixels beyond the sample ceiling are dropped outright, so the
        // sums can never overflow their 20 bits.
        if (px.alpha > 8'd25 && n_samples < MAX_SAMP) begin
            s = centered_sq(px.red) + centered_sq(px.green) + centered_sq(px.blue);
            sum_r = sum_r + px.red;
            sum_g = sum_g + px.green;
            sum_b = sum_b + px.blue;
            if (s >= 32513 && s <= 104040 && px.blue > 8'd102)
                n_valid = n_valid + 1'b1;
            n_samples = n_samples + 1'b1;
        end
        if (px.last) begin
            n  = n_samples;
            qr = 4 * sum_r;
            qg = 4 * sum_g;
            qb = 4 * sum_b;
            // Mean bounds are 0.35 and 0.65 of full scale times 255, scaled
            // by four so that every comparison is between exact integers.
            res.is_normal_map = !gray_cfg && n != 0 &&
                                10 * n_valid > 7 * n &&
                                qr > 357 * n && qr < 663 * n &&
                                qg > 357 * n && qg < 663 * n &&
                                qb > 663 * n;
            res.no_samples = (n == 0);
            verdict_q.push_back(res);
            sum_r = '0;
            sum_g = '0;
            sum_b = '0;
            n_samples = '0;
            n_valid = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued pixels, idling at random between requests.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        pixel_t nxt;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tally_pixel(cur_px);
                pixels_sent++;
            end
            // Only move on when the bus is free or the current request went.
            if (!s_tvalid || s_tready) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = pixel_q.pop_front();
                    cur_px   <= nxt;
                    s_tdata  <= {nxt.alpha, nxt.blue, nxt.green, nxt.red};
                    s_tlast  <= nxt.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes verdict requests and checks them field by field.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        nmc_result_t got;
        nmc_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[1:0];
                verdicts_seen++;
                if (verdict_q.size() == 0) begin
                    $error("unexpected verdict: is_normal_map=%0b no_samples=%0b",
                           got.is_normal_map, got.no_samples);
                    fail_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (want.is_normal_map) verdicts_true++;
                    if (want.no_samples) verdicts_empty++;
                    if (got.is_normal_map !== want.is_normal_map) begin
                        $error("is_normal_map: expected %0b, got %0b",
                               want.is_normal_map, got.is_normal_map);
                        fail_cnt++;
                    end
                    if (got.no_samples !== want.no_samples) begin
                        $error("no_samples: expected %0b, got %0b",
                               want.no_samples, got.no_samples);
                        fail_cnt++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Receiver hold-off: starts once when requested, then counts down one
    // cycle per clock.
    always @(posedge aclk) begin
        if (hold_go && !hold_armed) begin
            hold_armed <= 1'b1;
            hold_left  <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic pixel_t normal_px();
        pixel_t px;
        px.red   = 8'($urandom_range(155, 100));
        px.green = 8'($urandom_range(155, 100));
        px.blue  = 8'($urandom_range(255, 230));
        px.alpha = 8'($urandom_range(255, 26));
        px.last  = 1'b0;
        return px;
    endfunction

    // A red or green value just either side of the mean limits.
    function automatic logic [7:0] near_mean_limit();
        case ($urandom_range(3))
            0: return 8'd89;
            1: return 8'd90;
            2: return 8'd165;
            default: return 8'd166;
        endcase
    endfunction

    function automatic pixel_t make_px(input img_kind_t kind);
        pixel_t px;
        px = pixel_t'({1'b0, $urandom});
        case (kind)
            IMG_NORMAL: begin
                if ($urandom_range(99) < 88)
                    px = normal_px();
                if ($urandom_range(99) < 5)
                    px.alpha = 8'($urandom_range(25));
            end
            IMG_BORDER: begin
                px = normal_px();
                if ($urandom_range(1)) px.red = near_mean_limit();
                if ($urandom_range(1)) px.green = near_mean_limit();
                case ($urandom_range(3))
                    0: px.blue = 8'($urandom_range(166, 165));
                    1: px.blue = 8'($urandom_range(103, 102));
                    default: ;
                endcase
                if ($urandom_range(99) < 30) px.alpha = 8'($urandom_range(26, 25));
            end
            IMG_SPARSE: begin
                if ($urandom_range(99) < 85)
                    px.alpha = 8'($urandom_range(25));
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic push_px(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic [7:0] a, input logic last);
        pixel_q.push_back({last, a, b, g, r});
    endtask

    task automatic queue_image(input img_kind_t kind, input int len);
        pixel_t px;
        for (int i = 0; i < len; i++) begin
            px = make_px(kind);
            px.last = (i == len - 1);
            pixel_q.push_back(px);
        end
    endtask

    // Returns on a falling edge once every pixel is taken, every verdict
    // is back and the pipeline has had time to empty.
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (pixel_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_gray(input logic v);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        gray_cfg = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // Random images until about the requested number of pixels is queued.
    task automatic run_random(input int target);
        int pushed;
        int len;
        int roll;
        img_kind_t kind;
        pushed = 0;
        while (pushed < target) begin
            roll = $urandom_range(99);
            kind = (roll < 55) ? IMG_NORMAL :
                   (roll < 70) ? IMG_BORDER :
                   (roll < 90) ? IMG_NOISE : IMG_SPARSE;
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            queue_image(kind, len);
            pushed += len;
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int waited;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_gray(1'b0);

        // Directed images, each closed by its last pixel.
        set_idling(27, 75);
        push_px(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);              // nothing passes alpha
        push_px(8'd255, 8'd255, 8'd255, 8'd25, 1'b1);       // alpha right at the cutoff
        push_px(8'd128, 8'd128, 8'd255, 8'd26, 1'b1);       // one clean normal
        push_px(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);      // vector far too long
        // The last pixel is skipped, yet the image still gets its verdict.
        push_px(8'd128, 8'd128, 8'd255, 8'd255, 1'b0);
        push_px(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        // Blue of 102 is not enough for a valid normal, 103 is; with two
        // clean normals in front this decides the valid-fraction test.
        push_px(8'd128, 8'd128, 8'd255, 8'd255, 1'b0);
        push_px(8'd128, 8'd128, 8'd255, 8'd255, 1'b0);
        push_px(8'd189, 8'd66, 8'd102, 8'd255, 1'b1);
        push_px(8'd128, 8'd128, 8'd255, 8'd255, 1'b0);
        push_px(8'd128, 8'd128, 8'd255, 8'd255, 1'b0);
        push_px(8'd189, 8'd66, 8'd103, 8'd255, 1'b1);
        // Channel means just inside and just outside their limits.
        push_px(8'd90, 8'd165, 8'd255, 8'd200, 1'b1);
        push_px(8'd89, 8'd165, 8'd255, 8'd200, 1'b1);
        push_px(8'd90, 8'd166, 8'd255, 8'd200, 1'b1);
        push_px(8'd0, 8'd255, 8'd0, 8'd255, 1'b1);
        wait_idle();

        // Grayscale source forces every verdict low; no_samples still reports.
        write_gray(1'b1);
        set_idling(27, 75);
        push_px(8'd128, 8'd128, 8'd255, 8'd255, 1'b1);
        push_px(8'd128, 8'd128, 8'd255, 8'd10, 1'b1);
        run_random(80);

        write_gray(1'b0);
        run_random(110);

        set_idling(75, 27);
        run_random(180);

        // Back pressure: the receiver stops for a long stretch while short
        // images keep coming, so the verdict queue fills and s_tready drops.
        set_idling(0, 0);
        hold_go = 1'b1;
        for (int i = 0; i < 30; i++)
            queue_image(IMG_NORMAL, $urandom_range(2, 1));
        wait_idle();

        write_gray(1'b1);
        run_random(40);
        write_gray(1'b0);
        run_random(100);

        // A dangling image that never ends must produce nothing.
        queue_image(IMG_NOISE, 3);
        pixel_q[pixel_q.size() - 1].last = 1'b0;

        do
            @(negedge aclk);
        while (pixel_q.size() != 0 || s_tvalid);
        waited = 0;
        while (verdict_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE) @(negedge aclk);
        if (verdict_q.size() != 0) begin
            $error("%0d verdicts never arrived", verdict_q.size());
            fail_cnt++;
        end

        $display("Sent %0d pixel requests and checked %0d verdicts (%0d positive, %0d empty),",
                 pixels_sent, verdicts_seen, verdicts_true, verdicts_empty);
        $display("across both grayscale settings, three idle patterns and one long stall.");
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
